[design/tdpt_pkg.sv]
// ----------------------------------------------------------------------------
// Trial-division prime test package
// Shared widths and types for the trial-division prime tester.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    // Width of the candidate number.
    localparam int VALUE_BITS = 31;

    // Width of the trial divisor. The divisor never exceeds sqrt(candidate) + 1.
    localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;

    // Width of the running divisor square. It stays below twice the largest
    // candidate.
    localparam int SQ_BITS = VALUE_BITS + 1;

    // Width of the bit counter inside the remainder unit.
    localparam int CNT_BITS = $clog2(VALUE_BITS);

    // Status that the remainder unit returns to the sequencer.
    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

endpackage

[design/tdpt_rem_unit.sv]
// ----------------------------------------------------------------------------
// Trial-division remainder unit
// Bit-serial restoring remainder: one numerator bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module tdpt_rem_unit
    import tdpt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] numerator,
    input  logic [DIV_BITS-1:0]   divisor,
    output rem_status_t           status
);

    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    logic [CNT_BITS-1:0]   cnt_reg,   cnt_next;
    logic [VALUE_BITS-1:0] num_reg,   num_next;
    logic [DIV_BITS-1:0]   dsr_reg,   dsr_next;
    logic [DIV_BITS-1:0]   rem_reg,   rem_next;
    logic [DIV_BITS:0]     trial;
    logic [DIV_BITS:0]     diff;

    // One restoring step: shift in the next numerator bit and subtract if it fits.
    assign trial = {rem_reg, num_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(VALUE_BITS - 1);
            num_next  = numerator;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            num_next = {num_reg[VALUE_BITS-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = diff[DIV_BITS-1:0];
            end else begin
                rem_next = trial[DIV_BITS-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // The busy and done flags are reset; the bit counter and datapath registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

[design/trial_division_prime_test_top.sv]
// ----------------------------------------------------------------------------
// Trial-division prime test, top level
// Tests one candidate at a time for primality by trial division and returns
// the candidate with a prime flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready/s_candidate takes one candidate per transfer.
//   Output channel m_valid/m_ready/m_tested_value/m_is_prime returns exactly
//   one result per candidate, in order.
//   The block works on one candidate at a time: s_ready is high only while
//   the block is idle, and it drops from the transfer until the result has
//   been taken.
//   Each trial divisor costs a square check that also starts the remainder
//   unit, the bit-serial remainder itself, and a step to take its verdict.
//   Candidates 0 and 1 skip the divisors; the worst case at 31 bits is a
//   large prime, with about 46340 divisors tried.
//   The divisor square is tracked by adding 2d + 1 per step, so no
//   multiplier is needed.
//   When the receiver stalls, the result holds on the output registers and
//   no new candidate is taken until it is transferred.
//   Reset (aresetn low, synchronous) returns the block to idle and drops
//   any test or result in flight.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top
    import tdpt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_candidate,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_tested_value,
    output logic                  m_is_prime
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WAIT,
        ST_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] n_reg,     n_next;
    logic [DIV_BITS-1:0]   d_reg,     d_next;
    logic [SQ_BITS-1:0]    sq_reg,    sq_next;
    logic                  prime_reg, prime_next;
    logic                  rem_start;
    rem_status_t           rem_stat;

    // Shared remainder unit.
    tdpt_rem_unit u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .numerator (n_reg),
        .divisor   (d_reg),
        .status    (rem_stat)
    );

    // Sequencer: step the divisor until its square exceeds the candidate or it divides the candidate.
    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        prime_next = prime_reg;
        rem_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    n_next = s_candidate;
                    d_next = DIV_BITS'(2);
                    sq_next = SQ_BITS'(4);
                    if (s_candidate < VALUE_BITS'(2)) begin
                        prime_next = 1'b0;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (sq_reg > {1'b0, n_reg}) begin
                    prime_next = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    rem_start  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (rem_stat.done) begin
                    if (rem_stat.zero) begin
                        prime_next = 1'b0;
                        state_next = ST_OUT;
                    end else begin
                        d_next     = d_reg + 1'b1;
                        sq_next    = sq_reg + SQ_BITS'({d_reg, 1'b1});
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        n_reg     <= n_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        prime_reg <= prime_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = (state_reg == ST_OUT);
    assign m_tested_value = n_reg;
    assign m_is_prime     = prime_reg;

    // The block never offers a result while it takes a new candidate.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("s_ready and m_valid high together");

    // A prime verdict is only given for candidates of two or more.
    a_prime_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_prime) |-> (m_tested_value >= VALUE_BITS'(2)))
        else $error("prime flag on a candidate below two");

    // The remainder unit only reports completion while the sequencer waits.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_stat.done |-> (state_reg == ST_WAIT))
        else $error("remainder completion outside the wait state");

    // The divisor advances by one after a nonzero remainder.
    a_sq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT && rem_stat.done && !rem_stat.zero)
        |=> (state_reg == ST_CHECK) && (d_reg == $past(d_reg) + 1'b1))
        else $error("divisor did not advance after a nonzero remainder");

endmodule

[tb/sv/tb_trial_division_prime_test_top.sv]
// ----------------------------------------------------------------------------
// Trial-division prime test testbench
// Sends candidate numbers through the valid/ready input channel and checks
// every result against a trial-division verdict computed here. Small numbers,
// the field extremes, square boundaries, output back-pressure and a random mix
// are each run by their own task while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_trial_division_prime_test_top
    import tdpt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any transfer before the run is declared hung. The slowest
    // correct test is a prime near the top of the range.
    localparam int STALL_LIMIT   = 5_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 64;
    localparam int RANDOM_ITEMS  = 80;
    localparam int MAX_IDLE      = 14;

    typedef struct packed {
        logic [VALUE_BITS-1:0] tested_value;
        logic                  is_prime;
    } prime_verdict_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [VALUE_BITS-1:0] s_candidate = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [VALUE_BITS-1:0] m_tested_value;
    logic                  m_is_prime;

    prime_verdict_t pending_verdicts[$];
    int             error_count = 0;
    int             quiet_cycles = 0;
    bit             no_idle = 1'b0;
    bit             hold_results = 1'b0;

    trial_division_prime_test_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_candidate    (s_candidate),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_tested_value (m_tested_value),
        .m_is_prime     (m_is_prime)
    );

    always #2 aclk = ~aclk;

    // Verdict by plain trial division; the square is formed at 64 bits.
    function automatic prime_verdict_t trial_division_verdict(logic [VALUE_BITS-1:0] n);
        longint unsigned value;
        longint unsigned divisor;
        prime_verdict_t  verdict;
        value = n;
        verdict.tested_value = n;
        verdict.is_prime = (value >= 2);
        for (divisor = 2; verdict.is_prime && divisor * divisor <= value; divisor++) begin
            if (value % divisor == 0) begin
                verdict.is_prime = 1'b0;
            end
        end
        return verdict;
    endfunction

    // Offer one candidate after a random gap and hold it until the transfer.
    task automatic send_candidate(logic [VALUE_BITS-1:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_candidate <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    // Zero and one are not prime; two and three need no divisor at all.
    task automatic test_small_numbers();
        int n;
        for (n = 0; n <= 5; n++) begin
            send_candidate(VALUE_BITS'(n));
        end
    endtask

    // Top of the range is the prime 2^31 - 1, the slowest case there is.
    task automatic test_field_extremes();
        send_candidate({VALUE_BITS{1'b1}});
        send_candidate({{(VALUE_BITS-1){1'b1}}, 1'b0});
        send_candidate(VALUE_BITS'(1) << (VALUE_BITS - 1));
        send_candidate((VALUE_BITS'(1) << (VALUE_BITS - 1)) + VALUE_BITS'(1));
    endtask

    // Squares of primes are found only on the last divisor, where d*d equals n.
    task automatic test_square_boundaries();
        send_candidate(VALUE_BITS'(9));
        send_candidate(VALUE_BITS'(25));
        send_candidate(VALUE_BITS'(49));
        send_candidate(VALUE_BITS'(9409));
        send_candidate(VALUE_BITS'(64507));
        send_candidate(VALUE_BITS'(65535));
        send_candidate(VALUE_BITS'(65537));
    endtask

    // The receiver stops for a long stretch while candidates keep coming.
    task automatic test_output_backpressure();
        hold_results = 1'b1;
        send_candidate(VALUE_BITS'(121));
        send_candidate(VALUE_BITS'(6));
        send_candidate(VALUE_BITS'(7919));
        send_candidate(VALUE_BITS'(1000003));
    endtask

    // Mostly small and medium numbers; large ones carry a small factor so that
    // every bit is exercised without the cost of a large prime.
    task automatic test_random_candidates();
        int                    i;
        int                    kind;
        logic [VALUE_BITS-1:0] n;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 20 == 0) begin
                no_idle = ($urandom_range(2, 0) == 0);
            end
            kind = $urandom_range(99, 0);
            if (kind < 45) begin
                n = VALUE_BITS'($urandom_range(2000, 0));
            end else if (kind < 65) begin
                n = VALUE_BITS'($urandom_range(1 << 20, 0));
            end else if (kind < 85) begin
                n = VALUE_BITS'($urandom());
                n[0] = 1'b0;
            end else begin
                n = VALUE_BITS'(3 * $urandom_range(715827882, 0));
            end
            send_candidate(n);
        end
        no_idle = 1'b0;
    endtask

    // Receiver: random stall per result, plus one long hold when requested.
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_results = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // Check each result transfer, then record the verdict for each input transfer.
    always @(posedge aclk) begin
        prime_verdict_t expected;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    $error("unexpected result: tested_value %0d, is_prime %0d",
                           m_tested_value, m_is_prime);
                    error_count++;
                end else begin
                    expected = pending_verdicts.pop_front();
                    if (m_tested_value !== expected.tested_value) begin
                        $error("tested_value: expected %0d, actual %0d",
                               expected.tested_value, m_tested_value);
                        error_count++;
                    end
                    if (m_is_prime !== expected.is_prime) begin
                        $error("is_prime: expected %0d, actual %0d (candidate %0d)",
                               expected.is_prime, m_is_prime, expected.tested_value);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_verdicts.push_back(trial_division_verdict(s_candidate));
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_small_numbers();
        test_field_extremes();
        test_square_boundaries();
        test_output_backpressure();
        test_random_candidates();

        // The last transfer is recorded at the edge that ended the sender, so drop
        // s_valid and wait for the next edge before looking at the queue.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (pending_verdicts.size() != 0) begin
            $error("%0d results never arrived", pending_verdicts.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
design/tdpt_pkg.sv
design/tdpt_rem_unit.sv
design/trial_division_prime_test_top.sv
tb/sv/tb_trial_division_prime_test_top.sv
